/* rtl/core/mdts_pkg.sv */
`default_nettype none
package mdts_pkg;

  localparam int MAX_SAMPLES = 1024;
  localparam int MAX_LAG     = 4;

  localparam int SAMPLE_W  = 16;
  localparam int LAG_W     = 3;
  localparam int CVM_W     = 63;
  localparam int KS_W      = 27;
  localparam int STATUS_W  = 2;

  localparam int ADDR_W    = $clog2(MAX_SAMPLES);
  localparam int CNT_W     = ADDR_W + 1;
  localparam int TOTAL_W   = SAMPLE_W + ADDR_W + 1;
  localparam int NUM_W     = TOTAL_W + 1;
  localparam int QUO_W     = NUM_W - 1;
  localparam int DEN_W     = CNT_W + 1;
  localparam int DCNT_W    = $clog2(QUO_W);
  localparam int MEAN_W    = SAMPLE_W + 1;
  localparam int MARK_W    = SAMPLE_W + 2;
  localparam int ACC_W     = MARK_W + ADDR_W;
  localparam int MAG_W     = ACC_W - 1;
  localparam int WIN_IDX_W = (MAX_LAG > 1) ? $clog2(MAX_LAG) : 1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [LAG_W-1:0]           lag_t;
  typedef logic [CNT_W-1:0]           count_t;
  typedef logic [STATUS_W-1:0]        status_t;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FEW   = 2'd1;
  localparam status_t ST_TRUNC = 2'd2;

endpackage
`default_nettype wire

/* rtl/core/mdts_in_if.sv */
`default_nettype none
interface mdts_in_if;
  import mdts_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample;
  logic    last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface
`default_nettype wire

/* rtl/core/mdts_out_if.sv */
`default_nettype none
interface mdts_out_if;
  import mdts_pkg::*;

  logic             valid;
  logic             ready;
  logic [CVM_W-1:0] cvm_sum_sq;
  logic [KS_W-1:0]  ks_max_abs;
  count_t           sample_count;
  status_t          status;

  modport source (output valid, output cvm_sum_sq, output ks_max_abs,
                  output sample_count, output status, input ready);
  modport sink   (input valid, input cvm_sum_sq, input ks_max_abs,
                  input sample_count, input status, output ready);
endinterface
`default_nettype wire

/* rtl/core/mdts_cfg_if.sv */
`default_nettype none
interface mdts_cfg_if;
  import mdts_pkg::*;

  logic valid;
  logic ready;
  lag_t lag;

  modport source (output valid, output lag, input ready);
  modport sink   (input valid, input lag, output ready);
endinterface
`default_nettype wire

/* rtl/core/martingale_difference_test_stats_unit.sv */
`default_nettype none
// Marked empirical process statistics (CvM and KS numerators) over a series.
//
// in_ch  : one sample per beat; a beat with last set closes the series. While
//          samples load, ready stays high, so a beat is taken whenever valid is set.
//          Samples past the store depth are dropped and flag truncation.
// cfg_ch : writes the lag window length; always ready, write only when idle.
// out_ch : one result beat per series: CvM numerator, KS numerator, count
//          and status.
//
// After the closing beat the block drops in_ch.ready and computes. The mean
// comes from a one-bit-per-cycle divider with QUO_W = 27 quotient bits. Then,
// for each of the m = N - lag windows, the single read port of the sample
// store fetches the reference window and streams the whole series past it,
// followed by a square and an add. With N <= lag no window fits and the
// block goes straight to its result.
// A finished result waits in the output register; a stalled receiver holds
// it there, and the next series may load meanwhile, but its result waits.
// Reset clears the counters and sets lag to 1; the store needs no clearing.
module martingale_difference_test_stats_unit (
  input  wire         clk,
  input  wire         rst_n,
  mdts_in_if.sink     in_ch,
  mdts_cfg_if.sink    cfg_ch,
  mdts_out_if.source  out_ch
);
  import mdts_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_FIN, S_DIV, S_MEAN, S_JLD, S_SCAN, S_SQ, S_ACC, S_DONE
  } state_t;

  state_t state_r;

  // series bookkeeping
  lag_t                        lag_r;
  count_t                      count_r;
  logic signed [TOTAL_W-1:0]   total_r;
  logic                        ovf_r;
  status_t                     status_r;

  // sample store
  sample_t                     mem [MAX_SAMPLES];
  sample_t                     rd_q;
  logic [ADDR_W-1:0]           rd_addr;
  logic                        iss;
  logic                        wr_en;
  logic                        rd_vld_r;
  count_t                      rd_pos_r;

  // divider
  logic                        neg_r;
  logic [DEN_W-1:0]            rem_r;
  logic [QUO_W-1:0]            quo_r;
  logic [DCNT_W-1:0]           dcnt_r;
  logic signed [MEAN_W-1:0]    mean_r;

  // window sweep
  count_t                      j_r;
  count_t                      cnt_r;
  sample_t                     wj_r   [MAX_LAG];
  sample_t                     hist_r [MAX_LAG];
  logic signed [ACC_W-1:0]     acc_r;
  logic [2*MAG_W-1:0]          prod_r;
  logic [MAG_W-1:0]            ks_r;
  logic [CVM_W-1:0]            cvm_r;

  // output register
  logic                        out_valid_r;
  logic [CVM_W-1:0]            out_cvm_r;
  logic [KS_W-1:0]             out_ks_r;
  count_t                      out_cnt_r;
  status_t                     out_status_r;

  // combinational helpers
  lag_t                        p_eff;
  count_t                      p_cnt;
  count_t                      m_cnt;
  logic                        in_beat;
  logic                        room;
  logic signed [NUM_W-1:0]     num_s;
  logic [NUM_W-1:0]            num_abs;
  logic [DEN_W-1:0]            den;
  logic [DEN_W:0]              div_sh;
  logic                        div_ge;
  logic [MEAN_W-1:0]           mean_mag;
  logic signed [MARK_W-1:0]    mark;
  logic [LAG_W-1:0]            hidx [MAX_LAG];
  logic                        win_hit;
  logic signed [ACC_W-1:0]     acc_abs;
  logic [MAG_W-1:0]            mag;
  logic [CVM_W:0]              cvm_sum;
  logic                        out_free;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.cvm_sum_sq   = out_cvm_r;
  assign out_ch.ks_max_abs   = out_ks_r;
  assign out_ch.sample_count = out_cnt_r;
  assign out_ch.status       = out_status_r;

  assign in_beat  = in_ch.valid && (state_r == S_IDLE);
  assign room     = (count_r < CNT_W'(MAX_SAMPLES));
  assign wr_en    = in_beat && room;
  assign out_free = !out_valid_r || out_ch.ready;

  // Clamp lag into 1..MAX_LAG.
  always_comb begin
    if (lag_r == '0) begin
      p_eff = LAG_W'(1);
    end else if (lag_r > LAG_W'(MAX_LAG)) begin
      p_eff = LAG_W'(MAX_LAG);
    end else begin
      p_eff = lag_r;
    end
  end

  assign p_cnt = CNT_W'(p_eff);
  assign m_cnt = count_r - p_cnt;

  // Rounded mean numerator 2S + N and denominator 2N.
  assign num_s   = $signed({total_r, 1'b0}) + $signed({{(NUM_W-CNT_W){1'b0}}, count_r});
  assign num_abs = num_s[NUM_W-1] ? NUM_W'(-num_s) : NUM_W'(num_s);
  assign den     = {count_r, 1'b0};

  // One restoring divider step.
  assign div_sh = {rem_r, quo_r[QUO_W-1]};
  assign div_ge = (div_sh >= {1'b0, den});

  // Floor: a negative quotient with a remainder rounds one further down.
  assign mean_mag = quo_r[MEAN_W-1:0] + MEAN_W'(neg_r && (rem_r != '0));

  // Read address: reference window in S_JLD, whole series in S_SCAN.
  always_comb begin
    if (state_r == S_JLD) begin
      rd_addr = j_r[ADDR_W-1:0] + cnt_r[ADDR_W-1:0];
      iss     = (cnt_r < p_cnt);
    end else begin
      rd_addr = cnt_r[ADDR_W-1:0];
      iss     = (state_r == S_SCAN) && (cnt_r < count_r);
    end
  end

  assign mark = MARK_W'(rd_q) - MARK_W'(mean_r);

  // hist_r[0] holds the newest sample before the one arriving; entry k of the
  // candidate window sits at hist_r[p-1-k].
  always_comb begin
    win_hit = 1'b1;
    for (int k = 0; k < MAX_LAG; k++) begin
      hidx[k] = p_eff - LAG_W'(1) - LAG_W'(k);
      if ((LAG_W'(k) < p_eff) && (hist_r[hidx[k][WIN_IDX_W-1:0]] > wj_r[k])) begin
        win_hit = 1'b0;
      end
    end
  end

  assign acc_abs = acc_r[ACC_W-1] ? -acc_r : acc_r;
  assign mag     = acc_abs[MAG_W-1:0];
  assign cvm_sum = {1'b0, cvm_r} + (CVM_W+1)'(prod_r);

  // Sample store: one write port for loading, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[ADDR_W-1:0]] <= in_ch.sample;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lag_r       <= LAG_W'(1);
      count_r     <= '0;
      total_r     <= '0;
      ovf_r       <= 1'b0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r <= iss;
      if (iss) begin
        rd_pos_r <= cnt_r;
      end

      if (cfg_ch.valid) begin
        lag_r <= cfg_ch.lag;
      end

      // Load a finished result, or drop the beat the receiver just took.
      if ((state_r == S_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_beat) begin
            if (room) begin
              count_r <= count_r + CNT_W'(1);
              total_r <= total_r + TOTAL_W'(in_ch.sample);
            end else begin
              ovf_r <= 1'b1;
            end
            if (in_ch.last) begin
              state_r <= S_FIN;
            end
          end
        end

        S_FIN: begin
          cvm_r  <= '0;
          ks_r   <= '0;
          j_r    <= '0;
          rem_r  <= '0;
          dcnt_r <= '0;
          neg_r  <= num_s[NUM_W-1];
          quo_r  <= num_abs[QUO_W-1:0];
          if (count_r <= p_cnt) begin
            status_r <= ST_FEW;
            state_r  <= S_DONE;
          end else begin
            status_r <= ovf_r ? ST_TRUNC : ST_OK;
            state_r  <= S_DIV;
          end
        end

        S_DIV: begin
          rem_r  <= div_ge ? DEN_W'(div_sh - {1'b0, den}) : div_sh[DEN_W-1:0];
          quo_r  <= {quo_r[QUO_W-2:0], div_ge};
          dcnt_r <= dcnt_r + DCNT_W'(1);
          if (dcnt_r == DCNT_W'(QUO_W-1)) begin
            state_r <= S_MEAN;
          end
        end

        S_MEAN: begin
          mean_r  <= neg_r ? $signed(-mean_mag) : $signed(mean_mag);
          cnt_r   <= '0;
          state_r <= S_JLD;
        end

        S_JLD: begin
          if (iss) begin
            cnt_r <= cnt_r + CNT_W'(1);
          end
          if (rd_vld_r) begin
            wj_r[rd_pos_r[WIN_IDX_W-1:0]] <= rd_q;
          end
          // Last window word lands in this cycle.
          if (cnt_r == p_cnt) begin
            cnt_r   <= '0;
            acc_r   <= '0;
            state_r <= S_SCAN;
          end
        end

        S_SCAN: begin
          if (iss) begin
            cnt_r <= cnt_r + CNT_W'(1);
          end
          if (rd_vld_r) begin
            if ((rd_pos_r >= p_cnt) && win_hit) begin
              acc_r <= acc_r + ACC_W'(mark);
            end
            hist_r[0] <= rd_q;
            for (int i = 1; i < MAX_LAG; i++) begin
              hist_r[i] <= hist_r[i-1];
            end
          end
          // Final sample of the series arrives in this cycle.
          if (cnt_r == count_r) begin
            state_r <= S_SQ;
          end
        end

        S_SQ: begin
          prod_r <= mag * mag;
          if (mag > ks_r) begin
            ks_r <= mag;
          end
          state_r <= S_ACC;
        end

        S_ACC: begin
          cvm_r <= cvm_sum[CVM_W] ? {CVM_W{1'b1}} : cvm_sum[CVM_W-1:0];
          j_r   <= j_r + CNT_W'(1);
          cnt_r <= '0;
          if (j_r + CNT_W'(1) == m_cnt) begin
            state_r <= S_DONE;
          end else begin
            state_r <= S_JLD;
          end
        end

        S_DONE: begin
          if (out_free) begin
            out_cvm_r    <= cvm_r;
            out_ks_r     <= KS_W'(ks_r);
            out_cnt_r    <= count_r;
            out_status_r <= status_r;
            count_r      <= '0;
            total_r      <= '0;
            ovf_r        <= 1'b0;
            state_r      <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

/* dv/martingale_difference_test_stats_unit_test.sv */
`default_nettype none
module martingale_difference_test_stats_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import mdts_pkg::*;

  // The timeout guards the whole run, even with every series 64 samples long,
  // every one at lag 1 so that it has the most windows, and every stall drawn
  // at its longest; such a run still ends well inside CYCLE_LIMIT.
  localparam int unsigned CYCLE_LIMIT  = 400_000;
  localparam int          RANDOM_ITEMS = 545;
  localparam int          MAX_PRINTED  = 40;
  localparam int          IDLE_PAUSE   = 8;
  localparam int          END_PAUSE    = 50;

  localparam logic [CVM_W-1:0] CVM_SAT = '1;
  localparam logic [KS_W-1:0]  KS_SAT  = '1;

  typedef enum int {FULL_RANGE, NEAR_ZERO, RAILS, MIXED} sample_style_t;

  typedef struct {
    sample_t value;
    logic    closes;
  } series_item_t;

  typedef struct {
    logic [CVM_W-1:0] cvm;
    logic [KS_W-1:0]  ks;
    count_t           n;
    status_t          st;
  } series_stats_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  mdts_in_if  in_ch();
  mdts_cfg_if cfg_ch();
  mdts_out_if out_ch();

  martingale_difference_test_stats_unit dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .cfg_ch(cfg_ch),
    .out_ch(out_ch)
  );

  always #4ns clk = ~clk;

  // Samples waiting to be driven, and statistics waiting to come out.
  series_item_t  items_to_send[$];
  series_stats_t expected_stats[$];

  // Own copy of the block's state, advanced on every accepted beat.
  int          kept_samples[MAX_SAMPLES];
  int unsigned kept_count;
  longint      kept_total;
  bit          dropped_any;
  lag_t        model_lag;

  // Handshakes seen at the last rising edge, for the falling-edge drivers.
  logic in_fired;
  logic out_fired;

  int unsigned cycle_count;
  int unsigned mismatches;
  int unsigned samples_accepted;
  int unsigned series_closed;
  int unsigned results_checked;
  int unsigned truncated_series;
  logic [7:0]  lags_written;

  // Idle bookkeeping for both sides.
  int unsigned in_hold;
  bit          in_gaps_on = 1'b1;
  int unsigned out_hold;
  bit          out_armed;
  bit          out_gaps_on = 1'b1;

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    mismatches++;
    if (mismatches <= MAX_PRINTED)
      $display("mismatch at cycle %0d: %s got %0d, want %0d", cycle_count, what, got, want);
  endtask

  // Take one sample into the kept series; on the closing beat work out the
  // statistics the block must emit and clear the series state.
  task automatic absorb_sample(input sample_t s, input logic closes);
    series_stats_t r;
    int unsigned   n;
    int unsigned   p;
    int unsigned   m;
    longint        num;
    longint        den;
    longint        mean;
    longint        acc;
    longint unsigned mag;
    longint unsigned sq;
    longint unsigned cvm;
    longint unsigned ks;
    bit            below;
    if (kept_count < MAX_SAMPLES) begin
      kept_samples[kept_count] = int'(s);
      kept_count++;
      kept_total += longint'(s);
    end else begin
      // Store full: drop the sample but remember the series got cut.
      dropped_any = 1'b1;
    end
    if (closes) begin
      n   = kept_count;
      // Clamp the lag the same way the block does: 0 acts as 1.
      p   = (model_lag == 0) ? 1 : (model_lag > MAX_LAG) ? MAX_LAG : int'(model_lag);
      cvm = 0;
      ks  = 0;
      r.st = dropped_any ? ST_TRUNC : ST_OK;
      if (dropped_any)
        truncated_series++;
      if (n <= p) begin
        // No window fits: too few samples wins over truncation.
        r.st = ST_FEW;
      end else begin
        m    = n - p;
        // Mean rounded to nearest, ties toward plus infinity.
        num  = 2 * kept_total + longint'(n);
        den  = 2 * longint'(n);
        mean = (num >= 0) ? num / den : -((-num + den - 1) / den);
        for (int j = 0; j < m; j++) begin
          acc = 0;
          for (int t = 0; t < m; t++) begin
            below = 1'b1;
            for (int k = 0; k < p && below; k++)
              if (kept_samples[t + k] > kept_samples[j + k])
                below = 1'b0;
            if (below)
              acc += longint'(kept_samples[t + p]) - mean;
          end
          mag = (acc < 0) ? -acc : acc;
          if (mag > ks)
            ks = mag;
          sq  = (mag > 64'hFFFF_FFFF) ? CVM_SAT : mag * mag;
          cvm = (sq > CVM_SAT - cvm) ? CVM_SAT : cvm + sq;
        end
        if (ks > KS_SAT)
          ks = KS_SAT;
      end
      r.cvm = cvm[CVM_W-1:0];
      r.ks  = ks[KS_W-1:0];
      r.n   = n[CNT_W-1:0];
      expected_stats.push_back(r);
      series_closed++;
      kept_count  = 0;
      kept_total  = 0;
      dropped_any = 1'b0;
    end
  endtask

  task automatic enqueue(input sample_t v, input logic closes);
    series_item_t item;
    item.value  = v;
    item.closes = closes;
    items_to_send.push_back(item);
  endtask

  task automatic queue_random_series(input int len, input sample_style_t style);
    sample_style_t pick;
    sample_t       v;
    for (int i = 0; i < len; i++) begin
      pick = (style == MIXED) ? sample_style_t'($urandom_range(0, 2)) : style;
      case (pick)
        FULL_RANGE: v = sample_t'($urandom_range(0, 16'hFFFF));
        // Small values make equal entries, and with them ties in the window
        // comparison, common.
        NEAR_ZERO:  v = sample_t'(int'($urandom_range(0, 6)) - 3);
        default: begin
          case ($urandom_range(0, 2))
            0:       v = 16'sh7FFF;
            1:       v = 16'sh8000;
            default: v = '0;
          endcase
        end
      endcase
      enqueue(v, i == len - 1);
    end
  endtask

  // Hold until every sample went in and every result came out, then let the
  // block settle.
  task automatic wait_idle();
    while (items_to_send.size() != 0 || in_ch.valid || expected_stats.size() != 0)
      @(posedge clk);
    repeat (IDLE_PAUSE) @(posedge clk);
  endtask

  task automatic write_lag(input lag_t v);
    @(negedge clk);
    cfg_ch.lag   <= v;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    lags_written[v] = 1'b1;
  endtask

  // Monitor side: record handshakes, follow lag writes, advance the prediction, check results.
  always @(posedge clk) begin
    series_stats_t due;
    if (!rst_n) begin
      in_fired    <= 1'b0;
      out_fired   <= 1'b0;
      kept_count  = 0;
      kept_total  = 0;
      dropped_any = 1'b0;
      model_lag   = 1;
    end else begin
      in_fired  <= in_ch.valid && in_ch.ready;
      out_fired <= out_ch.valid && out_ch.ready;
      if (cfg_ch.valid && cfg_ch.ready)
        model_lag = cfg_ch.lag;
      if (in_ch.valid && in_ch.ready) begin
        samples_accepted++;
        absorb_sample(in_ch.sample, in_ch.last);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_stats.size() == 0) begin
          report_mismatch("result beat with none pending, sample_count",
                          out_ch.sample_count, 0);
        end else begin
          due = expected_stats.pop_front();
          results_checked++;
          if (out_ch.cvm_sum_sq !== due.cvm)
            report_mismatch("cvm_sum_sq", out_ch.cvm_sum_sq, due.cvm);
          if (out_ch.ks_max_abs !== due.ks)
            report_mismatch("ks_max_abs", out_ch.ks_max_abs, due.ks);
          if (out_ch.sample_count !== due.n)
            report_mismatch("sample_count", out_ch.sample_count, due.n);
          if (out_ch.status !== due.st)
            report_mismatch("status", out_ch.status, due.st);
        end
      end
    end
  end

  // Drive side: change inputs on the falling edge only.
  always @(negedge clk) begin
    logic         raise;
    series_item_t item;
    if (rst_n) begin
      // Keep valid up while the current beat is still waiting.
      raise = in_ch.valid && !in_fired;
      if (!raise) begin
        if (in_hold > 0) begin
          in_hold--;
        end else if (items_to_send.size() != 0) begin
          item = items_to_send.pop_front();
          in_ch.sample <= item.value;
          in_ch.last   <= item.closes;
          raise        = 1'b1;
          in_hold      = in_gaps_on ? $urandom_range(0, 7) : 0;
          // Switch idling on or off per series, so some run back to back.
          if (item.closes)
            in_gaps_on = ($urandom_range(0, 2) != 0);
        end
      end
      in_ch.valid <= raise;

      // Hold ready low on a new result at random; gaps are switched on or off per result.
      if (out_fired) begin
        out_armed   = 1'b0;
        out_gaps_on = ($urandom_range(0, 2) != 0);
      end
      if (out_ch.valid && !out_armed) begin
        out_armed = 1'b1;
        out_hold  = out_gaps_on ? $urandom_range(0, 7) : 0;
      end
      if (out_hold > 0) begin
        out_ch.ready <= 1'b0;
        out_hold--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timed out after %0d cycles, %0d results pending",
               cycle_count, expected_stats.size());
      $display("martingale_difference_test_stats_unit_test NOT OK");
      $finish;
    end
  end

  initial begin
    int sent;
    int len;
    in_ch.valid  = 1'b0;
    in_ch.sample = '0;
    in_ch.last   = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.lag   = '0;
    lags_written = '0;
    rst_n        = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Lag still at its reset value: full-scale extremes with both signs.
    enqueue(16'sh7FFF, 0); enqueue(16'sh8000, 0); enqueue(0, 0);
    enqueue(1, 0); enqueue(-1, 0); enqueue(16'sh7FFF, 1);
    // A lone sample has no window at any lag.
    enqueue(16'sh8000, 1);
    // Sum 3 over 2 samples: the rounding tie goes up to 2.
    enqueue(1, 0); enqueue(2, 1);

    wait_idle();
    write_lag(0);
    // Negative tie: sum -3 over 2 rounds up to -1.
    enqueue(-1, 0); enqueue(-2, 1);
    // Flat series: all windows equal, every centered mark is zero.
    enqueue(100, 0); enqueue(100, 0); enqueue(100, 1);

    wait_idle();
    write_lag(7);
    // Lag above the maximum clamps: 4 samples are too few, 5 give one window.
    enqueue(-7, 0); enqueue(3, 0); enqueue(9, 0); enqueue(-1, 1);
    enqueue(4, 0); enqueue(-5, 0); enqueue(6, 0); enqueue(2, 0); enqueue(-3, 1);

    wait_idle();
    write_lag(lag_t'(MAX_LAG));
    queue_random_series(7, FULL_RANGE);

    // Small values at lag 2 make ties in the window comparison common.
    wait_idle();
    write_lag(2);
    queue_random_series(4, NEAR_ZERO);

    // Random phases: a fresh lag, then a handful of series of varied shape.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_idle();
      write_lag(lag_t'($urandom_range(0, 7)));
      repeat ($urandom_range(2, 5)) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 20);
        queue_random_series(len, sample_style_t'($urandom_range(0, 3)));
        sent += len;
      end
    end

    wait_idle();
    repeat (END_PAUSE) @(posedge clk);
    if (expected_stats.size() != 0)
      report_mismatch("results never delivered", 0, expected_stats.size());
    $display("covered %0d series from %0d samples (%0d truncated), %0d results checked",
             series_closed, samples_accepted, truncated_series, results_checked);
    $display("lag settings written: %b (bit i = value i), %0d mismatches",
             lags_written, mismatches);
    if (mismatches == 0) begin
      $display("martingale_difference_test_stats_unit_test OK");
    end else begin
      $display("martingale_difference_test_stats_unit_test NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire
